// ===== hw/rtl/twr_pkg.sv =====
// Shared types and constants for the two-wire register access master.
// Used by twr_front, twr_queue, twr_engine and the top level.
package twr_pkg;

  // Request classification made by the front end
  localparam logic [1:0] KIND_TICK     = 2'd0;  // plain quantum, no start
  localparam logic [1:0] KIND_START_WR = 2'd1;  // start of a register write
  localparam logic [1:0] KIND_START_RD = 2'd2;  // start of a register read

  // Byte and bit bookkeeping
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [2:0] BYTE_RX_HIGH  = 3'd2;  // first byte clocked in on a read
  localparam logic [2:0] BYTE_RX_LOW   = 3'd3;  // second byte, answered with NACK
  localparam logic [2:0] BYTES_TOTAL   = 3'd4;

  // Device address after reset
  localparam logic [7:0] ADDR_RESET    = 8'h80;

  // One classified request as it travels through the queue
  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  reg_index;
    logic [15:0] write_data;
    logic        sda_in;
  } twr_item_t;

endpackage

// ===== hw/rtl/twr_front.sv =====
// Front end: takes requests off the input channel and classifies them.
// Depends on twr_pkg; feeds twr_queue.
module twr_front
  import twr_pkg::*;
(
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        start_req,
  input  logic        operation,
  input  logic [6:0]  reg_index,
  input  logic [15:0] write_data,
  input  logic        sda_in,
  input  logic        q_full,
  output logic        push,
  output twr_item_t   item
);

  // Stall only on a full queue, so output stalls reach the front once the queue fills
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Classify: a start request becomes a write or read start, else a tick
  always_comb begin
    item.reg_index  = reg_index;
    item.write_data = write_data;
    item.sda_in     = sda_in;
    if (!start_req) begin
      item.kind = KIND_TICK;
    end else if (operation) begin
      item.kind = KIND_START_RD;
    end else begin
      item.kind = KIND_START_WR;
    end
  end

endmodule

// ===== hw/rtl/twr_queue.sv =====
// Two-entry request queue between front end and bus engine.
// Depends on twr_pkg for the request type.
module twr_queue
  import twr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  twr_item_t item_in,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output twr_item_t item_out
);

  twr_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign item_out = mem[rd_ptr];

  // Occupancy follows push and pop
  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count_next;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= item_in;
  end

endmodule

// ===== hw/rtl/twr_engine.sv =====
// Back end: bus sequencer that turns each request into one line state,
// with a registered result stage. Depends on twr_pkg.
module twr_engine
  import twr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  device_address,
  input  logic        q_valid,
  input  twr_item_t   item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_out,
  output logic        sda_out,
  output logic        sda_drive,
  output logic        busy_res,
  output logic        done_res,
  output logic [15:0] read_result,
  output logic        ack_missing
);

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_START_FALL = 4'd1;
  localparam logic [3:0] PH_START_LOW  = 4'd2;
  localparam logic [3:0] PH_TX_LOW     = 4'd3;
  localparam logic [3:0] PH_TX_HIGH    = 4'd4;
  localparam logic [3:0] PH_TXACK_LOW  = 4'd5;
  localparam logic [3:0] PH_TXACK_HIGH = 4'd6;
  localparam logic [3:0] PH_RX_LOW     = 4'd7;
  localparam logic [3:0] PH_RX_HIGH    = 4'd8;
  localparam logic [3:0] PH_MACK_LOW   = 4'd9;
  localparam logic [3:0] PH_MACK_HIGH  = 4'd10;
  localparam logic [3:0] PH_STOP_A     = 4'd11;
  localparam logic [3:0] PH_STOP_B     = 4'd12;
  localparam logic [3:0] PH_STOP_C     = 4'd13;

  logic [3:0]  phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [6:0]  latched_index, latched_index_next;
  logic [15:0] latched_data, latched_data_next;
  logic        latched_is_read, latched_is_read_next;
  logic [15:0] assembled_read, assembled_read_next;
  logic        nack_seen, nack_seen_next;

  logic        scl, sda, drv, busy, done;
  logic [3:0]  bit_inc;
  logic [2:0]  byte_inc;
  logic [7:0]  rx_byte;
  logic        is_start;

  // Take a request whenever the result register is free or being emptied
  assign pop      = q_valid && (!out_valid || !out_stall);
  assign bit_inc  = bit_count + 4'd1;
  assign byte_inc = byte_count + 3'd1;
  assign rx_byte  = {shift_byte[6:0], item.sda_in};
  assign is_start = (item.kind == KIND_START_WR) || (item.kind == KIND_START_RD);

  // Sequencer: line levels for this quantum and the following state
  always_comb begin
    phase_next           = phase;
    bit_count_next       = bit_count;
    byte_count_next      = byte_count;
    shift_byte_next      = shift_byte;
    latched_index_next   = latched_index;
    latched_data_next    = latched_data;
    latched_is_read_next = latched_is_read;
    assembled_read_next  = assembled_read;
    nack_seen_next       = nack_seen;
    scl  = 1'b1;
    sda  = 1'b1;
    drv  = 1'b1;
    busy = 1'b1;
    done = 1'b0;
    unique case (phase)
      PH_START_FALL: begin
        sda        = 1'b0;
        phase_next = PH_START_LOW;
      end
      PH_START_LOW: begin
        scl        = 1'b0;
        sda        = 1'b0;
        phase_next = PH_TX_LOW;
      end
      PH_TX_LOW: begin
        scl        = 1'b0;
        sda        = shift_byte[7];
        phase_next = PH_TX_HIGH;
      end
      PH_TX_HIGH: begin
        sda             = shift_byte[7];
        shift_byte_next = {shift_byte[6:0], 1'b0};
        bit_count_next  = bit_inc;
        phase_next      = (bit_inc >= BITS_PER_BYTE) ? PH_TXACK_LOW : PH_TX_LOW;
      end
      PH_TXACK_LOW: begin
        scl        = 1'b0;
        drv        = 1'b0;
        phase_next = PH_TXACK_HIGH;
      end
      PH_TXACK_HIGH: begin
        drv             = 1'b0;
        nack_seen_next  = nack_seen | item.sda_in;
        byte_count_next = byte_inc;
        bit_count_next  = 4'd0;
        if (byte_inc >= BYTES_TOTAL) begin
          phase_next = PH_STOP_A;
        end else if (latched_is_read && byte_inc >= BYTE_RX_HIGH) begin
          shift_byte_next = 8'd0;
          phase_next      = PH_RX_LOW;
        end else begin
          // next byte to send: index byte, then data high, then data low
          case (byte_inc)
            3'd1:    shift_byte_next = {latched_index, latched_is_read};
            3'd2:    shift_byte_next = latched_data[15:8];
            default: shift_byte_next = latched_data[7:0];
          endcase
          phase_next = PH_TX_LOW;
        end
      end
      PH_RX_LOW: begin
        scl        = 1'b0;
        drv        = 1'b0;
        phase_next = PH_RX_HIGH;
      end
      PH_RX_HIGH: begin
        drv             = 1'b0;
        shift_byte_next = rx_byte;
        bit_count_next  = bit_inc;
        if (bit_inc >= BITS_PER_BYTE) begin
          if (byte_count == BYTE_RX_HIGH) begin
            latched_data_next = {rx_byte, 8'h00};
          end else begin
            assembled_read_next = {latched_data[15:8], rx_byte};
          end
          phase_next = PH_MACK_LOW;
        end else begin
          phase_next = PH_RX_LOW;
        end
      end
      PH_MACK_LOW: begin
        scl        = 1'b0;
        sda        = (byte_count >= BYTE_RX_LOW);
        phase_next = PH_MACK_HIGH;
      end
      PH_MACK_HIGH: begin
        sda             = (byte_count >= BYTE_RX_LOW);
        byte_count_next = byte_inc;
        bit_count_next  = 4'd0;
        shift_byte_next = 8'd0;
        phase_next      = (byte_inc >= BYTES_TOTAL) ? PH_STOP_A : PH_RX_LOW;
      end
      PH_STOP_A: begin
        scl        = 1'b0;
        sda        = 1'b0;
        phase_next = PH_STOP_B;
      end
      PH_STOP_B: begin
        sda        = 1'b0;
        phase_next = PH_STOP_C;
      end
      PH_STOP_C: begin
        done       = 1'b1;
        phase_next = PH_IDLE;
      end
      default: begin
        // idle: a start request latches the operands
        busy       = 1'b0;
        phase_next = PH_IDLE;
        if (is_start) begin
          latched_is_read_next = (item.kind == KIND_START_RD);
          latched_index_next   = item.reg_index;
          latched_data_next    = item.write_data;
          nack_seen_next       = 1'b0;
          bit_count_next       = 4'd0;
          byte_count_next      = 3'd0;
          shift_byte_next      = device_address;
          busy                 = 1'b1;
          phase_next           = PH_START_FALL;
        end
      end
    endcase
    // released line reads as high
    if (!drv) sda = 1'b1;
  end

  // Sequencer state, advanced once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_count       <= 4'd0;
      byte_count      <= 3'd0;
      shift_byte      <= 8'd0;
      latched_index   <= 7'd0;
      latched_data    <= 16'd0;
      latched_is_read <= 1'b0;
      assembled_read  <= 16'd0;
      nack_seen       <= 1'b0;
    end else if (pop) begin
      phase           <= phase_next;
      bit_count       <= bit_count_next;
      byte_count      <= byte_count_next;
      shift_byte      <= shift_byte_next;
      latched_index   <= latched_index_next;
      latched_data    <= latched_data_next;
      latched_is_read <= latched_is_read_next;
      assembled_read  <= assembled_read_next;
      nack_seen       <= nack_seen_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      scl_out     <= scl;
      sda_out     <= sda;
      sda_drive   <= drv;
      busy_res    <= busy;
      done_res    <= done;
      read_result <= assembled_read_next;
      ack_missing <= nack_seen_next;
    end
  end

  // Checks
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BITS_PER_BYTE)
    else $error("bit counter ran past one byte");

  a_byte_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= BYTES_TOTAL)
    else $error("byte counter ran past the transaction");

  a_stop_ends: assert property (@(posedge clk) disable iff (rst)
    (pop && phase == PH_STOP_C) |=> (phase == PH_IDLE))
    else $error("stop condition did not return to idle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (busy_res && scl_out && sda_out && sda_drive))
    else $error("done flagged outside a driven stop");

  a_rx_released: assert property (@(posedge clk) disable iff (rst)
    (pop && (phase == PH_RX_LOW || phase == PH_RX_HIGH)) |=> !sda_drive)
    else $error("data line driven while clocking in");

endmodule

// ===== hw/rtl/two_wire_register_access_master.sv =====
// Two-wire register access master, one bus timing quantum per request.
// Every accepted request yields exactly one result with the clock, data and
// data-enable levels for that quantum plus status. The block takes one request
// per clock cycle sustained while the output is not stalled; a result is
// presented on the output once its request has passed through the two-entry
// queue and the sequencer has registered its result as it takes it. The
// sequencer's phase register advances once per request. A write transaction
// spans 78 requests and a read 78 as well, from the start request to the
// quantum flagged done. The device address is taken from the configuration
// register when a start is accepted.
// Top level; depends on twr_pkg, twr_front, twr_queue and twr_engine.
module two_wire_register_access_master
  import twr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        start_req,
  input  logic        operation,
  input  logic [6:0]  reg_index,
  input  logic [15:0] write_data,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_out,
  output logic        sda_out,
  output logic        sda_drive,
  output logic        busy_res,
  output logic        done_res,
  output logic [15:0] read_result,
  output logic        ack_missing
);

  logic [7:0] device_address;
  logic       q_push;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  twr_item_t  front_item;
  twr_item_t  queue_item;

  // Device address register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= ADDR_RESET;
    end else if (cfg_we) begin
      device_address <= cfg_wdata;
    end
  end

  twr_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .start_req  (start_req),
    .operation  (operation),
    .reg_index  (reg_index),
    .write_data (write_data),
    .sda_in     (sda_in),
    .q_full     (q_full),
    .push       (q_push),
    .item       (front_item)
  );

  twr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (front_item),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .item_out (queue_item)
  );

  twr_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .device_address (device_address),
    .q_valid        (q_valid),
    .item           (queue_item),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .scl_out        (scl_out),
    .sda_out        (sda_out),
    .sda_drive      (sda_drive),
    .busy_res       (busy_res),
    .done_res       (done_res),
    .read_result    (read_result),
    .ack_missing    (ack_missing)
  );

endmodule
